/* src/aolq_pkg.sv */
package aolq_pkg;

  // Field widths of the item and result beats.
  localparam int NODE_W    = 16;
  localparam int COST_W    = 16;
  localparam int H_W       = 9;
  localparam int RES_W     = 8;
  localparam int POS_W     = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int PLC_W     = 2;
  localparam int OCC_W     = 7;

  // Action codes of an input beat.
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_POP    = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_Y  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_COST = 2'd2;

  localparam logic [CFG_W-1:0] BASE_COST_RESET = 8'd10;

  // Where an inserted node landed in the sorted store.
  typedef enum logic [PLC_W-1:0] {
    PLC_FRONT   = 2'd0,
    PLC_BACK    = 2'd1,
    PLC_GREATER = 2'd2,
    PLC_TIE     = 2'd3
  } placement_t;

  // One stored entry of the open list.
  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [COST_W-1:0] g;
    logic [H_W-1:0]    h;
    logic [COST_W-1:0] f;
  } entry_t;

  // Node with its computed costs, as produced by the cost unit.
  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [COST_W-1:0] g;
    logic [H_W-1:0]    h;
    logic [COST_W-1:0] f;
    logic              reached;
  } key_t;

  // What a cell loads in the write cycle.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_LEFT,
    OP_RIGHT
  } cell_op_t;

  // Compare results of a cell against the key being inserted.
  typedef struct packed {
    logic gt;
    logic eq;
    logic hge;
  } cell_flags_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEY,
    ST_CMP,
    ST_WRITE
  } state_t;

endpackage

/* src/aolq_key.sv */
module aolq_key #(
  parameter int COORD_BITS = 8
) (
  input  logic                       clk,
  input  logic                       ld_in,
  input  logic                       ld_cost,
  input  logic [aolq_pkg::NODE_W-1:0] node_id,
  input  logic [aolq_pkg::COST_W-1:0] parent_g,
  input  logic [aolq_pkg::RES_W-1:0]  resistance,
  input  logic [aolq_pkg::POS_W-1:0]  node_x,
  input  logic [aolq_pkg::POS_W-1:0]  node_y,
  input  logic [aolq_pkg::POS_W-1:0]  target_x,
  input  logic [aolq_pkg::POS_W-1:0]  target_y,
  input  logic [aolq_pkg::CFG_W-1:0]  base_cost,
  output aolq_pkg::key_t              key
);
  import aolq_pkg::*;

  // Coordinates are compared in their low bits only.
  localparam int CW = (COORD_BITS < POS_W) ? COORD_BITS : POS_W;

  logic [CW-1:0]     nx, ny, tx, ty, dx, dy;
  logic [NODE_W-1:0] node_r;
  logic [COST_W-1:0] pg_r;
  logic [COST_W-1:0] prod_r, prod_nxt;
  logic [H_W-1:0]    h_r, h_nxt;
  logic              reached_r, reached_nxt;
  logic [COST_W:0]   g_sum, f_sum;
  logic [COST_W-1:0] g_sat, f_sat;
  key_t              key_r, key_nxt;

  // First stage: step cost product, Manhattan distance and target test.
  always_comb begin
    nx          = node_x[CW-1:0];
    ny          = node_y[CW-1:0];
    tx          = target_x[CW-1:0];
    ty          = target_y[CW-1:0];
    dx          = (nx > tx) ? (nx - tx) : (tx - nx);
    dy          = (ny > ty) ? (ny - ty) : (ty - ny);
    h_nxt       = H_W'(dx) + H_W'(dy);
    reached_nxt = (nx == tx) && (ny == ty);
    prod_nxt    = COST_W'(base_cost) * COST_W'(resistance);
  end

  always_ff @(posedge clk) begin
    if (ld_in) begin
      node_r    <= node_id;
      pg_r      <= parent_g;
      prod_r    <= prod_nxt;
      h_r       <= h_nxt;
      reached_r <= reached_nxt;
    end
  end

  // Second stage: saturating g and f. On the target h is zero, so f equals g.
  always_comb begin
    g_sum   = {1'b0, pg_r} + {1'b0, prod_r};
    g_sat   = g_sum[COST_W] ? {COST_W{1'b1}} : g_sum[COST_W-1:0];
    f_sum   = {1'b0, g_sat} + (COST_W + 1)'(h_r);
    f_sat   = f_sum[COST_W] ? {COST_W{1'b1}} : f_sum[COST_W-1:0];
    key_nxt = '{node: node_r, g: g_sat, h: h_r, f: f_sat, reached: reached_r};
  end

  always_ff @(posedge clk) begin
    if (ld_cost) begin
      key_r <= key_nxt;
    end
  end

  assign key = key_r;

endmodule

/* src/aolq_cell.sv */
module aolq_cell (
  input  logic                        clk,
  input  aolq_pkg::cell_op_t          op,
  input  logic                        cmp_en,
  input  aolq_pkg::entry_t            new_ent,
  input  aolq_pkg::entry_t            left_ent,
  input  aolq_pkg::entry_t            right_ent,
  input  logic [aolq_pkg::COST_W-1:0] key_f,
  input  logic [aolq_pkg::H_W-1:0]    key_h,
  output aolq_pkg::entry_t            ent,
  output aolq_pkg::cell_flags_t       flags
);
  import aolq_pkg::*;

  entry_t      ent_r, ent_nxt;
  cell_flags_t flags_r, flags_nxt;

  // Entry source: keep, take the new node, or shift from a neighbor.
  always_comb begin
    unique case (op)
      OP_HOLD:  ent_nxt = ent_r;
      OP_LOAD:  ent_nxt = new_ent;
      OP_LEFT:  ent_nxt = left_ent;
      OP_RIGHT: ent_nxt = right_ent;
      default:  ent_nxt = ent_r;
    endcase
  end

  // Local compare of the held entry against the key.
  always_comb begin
    flags_nxt.gt  = ent_r.f > key_f;
    flags_nxt.eq  = ent_r.f == key_f;
    flags_nxt.hge = ent_r.h >= key_h;
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    if (cmp_en) begin
      flags_r <= flags_nxt;
    end
  end

  assign ent   = ent_r;
  assign flags = flags_r;

endmodule

/* src/astar_open_list_queue.sv */
// Bounded A* open list built as a row of QUEUE_DEPTH identical cells, each
// holding one entry, kept sorted by f with ties broken by h (a tie with the
// head always puts the new node first). The block works on one beat at a
// time: a pop is accepted and then the whole row shifts one cell toward the
// head, and an insert is accepted with the step-cost multiply and distance,
// then saturating g and f, a parallel compare in every cell, then the row
// opens a gap and the new node is written. in_ready is high only while no
// beat is in progress; the result sits in an output register, so the next
// beat is accepted while the previous result still waits, and only the final
// write cycle stalls on it. Configuration writes are taken in any cycle and
// must be made while the block is idle. No clearing pass is needed after reset.
module astar_open_list_queue #(
  parameter int QUEUE_DEPTH = 64,
  parameter int COORD_BITS  = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic [aolq_pkg::NODE_W-1:0]   in_node_id,
  input  logic [aolq_pkg::COST_W-1:0]   in_parent_g,
  input  logic [aolq_pkg::RES_W-1:0]    in_resistance,
  input  logic [aolq_pkg::POS_W-1:0]    in_node_x,
  input  logic [aolq_pkg::POS_W-1:0]    in_node_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [aolq_pkg::NODE_W-1:0]   out_node,
  output logic [aolq_pkg::COST_W-1:0]   out_g,
  output logic [aolq_pkg::H_W-1:0]      out_h,
  output logic [aolq_pkg::COST_W-1:0]   out_f,
  output logic                          out_reached,
  output logic [aolq_pkg::PLC_W-1:0]    out_placement,
  output logic                          out_empty_pop,
  output logic                          out_overflow,
  output logic [aolq_pkg::OCC_W-1:0]    out_occupancy,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [aolq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aolq_pkg::CFG_W-1:0]    cfg_data
);
  import aolq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int LV    = $clog2(QUEUE_DEPTH);

  state_t            state_r, state_nxt;
  logic              action_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [POS_W-1:0]  tx_r, ty_r;
  logic [CFG_W-1:0]  bc_r;
  logic              ld_in, ld_cost, cmp_en, commit;
  key_t              key;
  entry_t            new_ent;

  logic              out_valid_r, out_valid_nxt;
  entry_t            out_ent_r, out_ent_nxt;
  logic              out_reached_r, out_reached_nxt;
  placement_t        out_plc_r, out_plc_nxt;
  logic              out_empty_r, out_empty_nxt;
  logic              out_ovf_r, out_ovf_nxt;
  logic [OCC_W-1:0]  out_occ_r, out_occ_nxt;

  entry_t            cell_ent [QUEUE_DEPTH];
  cell_flags_t       cell_flg [QUEUE_DEPTH];
  cell_op_t          cell_op  [QUEUE_DEPTH];

  logic [QUEUE_DEPTH-1:0] valid_vec, hit_vec, gt_vec;
  logic [QUEUE_DEPTH-1:0] incl_vec, tmp_vec, before_vec, first_vec;
  logic                   any_hit;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_r <= '0;
      ty_r <= '0;
      bc_r <= BASE_COST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TARGET_X:  tx_r <= cfg_data;
        CFG_TARGET_Y:  ty_r <= cfg_data;
        CFG_BASE_COST: bc_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Cost unit: g, h, f and the target test of the node being inserted.
  aolq_key #(
    .COORD_BITS (COORD_BITS)
  ) u_key (
    .clk        (clk),
    .ld_in      (ld_in),
    .ld_cost    (ld_cost),
    .node_id    (in_node_id),
    .parent_g   (in_parent_g),
    .resistance (in_resistance),
    .node_x     (in_node_x),
    .node_y     (in_node_y),
    .target_x   (tx_r),
    .target_y   (ty_r),
    .base_cost  (bc_r),
    .key        (key)
  );

  assign new_ent = '{node: key.node, g: key.g, h: key.h, f: key.f};

  // Row of cells; the head is cell 0.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    aolq_cell u_cell (
      .clk       (clk),
      .op        (cell_op[i]),
      .cmp_en    (cmp_en),
      .new_ent   (new_ent),
      .left_ent  (cell_ent[(i == 0) ? 0 : i - 1]),
      .right_ent (cell_ent[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
      .key_f     (key.f),
      .key_h     (key.h),
      .ent       (cell_ent[i]),
      .flags     (cell_flg[i])
    );

    // The head takes the node on any equal f; other cells need h no smaller.
    assign valid_vec[i] = CNT_W'(i) < count_r;
    assign gt_vec[i]    = cell_flg[i].gt;
    assign hit_vec[i]   = valid_vec[i] & (cell_flg[i].gt |
                          (cell_flg[i].eq & ((i == 0) ? 1'b1 : cell_flg[i].hge)));
  end

  // Parallel prefix OR finds the first cell that the node goes before.
  always_comb begin
    incl_vec = hit_vec;
    tmp_vec  = hit_vec;
    for (int l = 0; l < LV; l++) begin
      tmp_vec = incl_vec;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (i >= (1 << l)) begin
          incl_vec[i] = tmp_vec[i] | tmp_vec[i - (1 << l)];
        end
      end
    end
    before_vec = {incl_vec[QUEUE_DEPTH-2:0], 1'b0};
    first_vec  = hit_vec & ~before_vec;
    any_hit    = incl_vec[QUEUE_DEPTH-1];
  end

  // Sequencer state and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_in) begin
      action_r <= in_action;
    end
    out_ent_r     <= out_ent_nxt;
    out_reached_r <= out_reached_nxt;
    out_plc_r     <= out_plc_nxt;
    out_empty_r   <= out_empty_nxt;
    out_ovf_r     <= out_ovf_nxt;
    out_occ_r     <= out_occ_nxt;
  end

  // Next state, cell operations and the result beat.
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    in_ready        = 1'b0;
    ld_in           = 1'b0;
    ld_cost         = 1'b0;
    cmp_en          = 1'b0;
    commit          = 1'b0;
    out_valid_nxt   = out_valid_r & ~out_ready;
    out_ent_nxt     = out_ent_r;
    out_reached_nxt = out_reached_r;
    out_plc_nxt     = out_plc_r;
    out_empty_nxt   = out_empty_r;
    out_ovf_nxt     = out_ovf_r;
    out_occ_nxt     = out_occ_r;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      cell_op[i] = OP_HOLD;
    end

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ld_in     = 1'b1;
          state_nxt = (in_action == ACT_POP) ? ST_WRITE : ST_KEY;
        end
      end
      ST_KEY: begin
        ld_cost   = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        cmp_en    = 1'b1;
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (!out_valid_r || out_ready) begin
          commit          = 1'b1;
          state_nxt       = ST_IDLE;
          out_valid_nxt   = 1'b1;
          out_ent_nxt     = new_ent;
          out_reached_nxt = 1'b0;
          out_plc_nxt     = PLC_FRONT;
          out_empty_nxt   = 1'b0;
          out_ovf_nxt     = 1'b0;
          priority if (action_r == ACT_POP) begin
            if (count_r == '0) begin
              out_ent_nxt   = '0;
              out_empty_nxt = 1'b1;
            end else begin
              out_ent_nxt = cell_ent[0];
              count_nxt   = count_r - CNT_W'(1);
              for (int i = 0; i < QUEUE_DEPTH; i++) begin
                cell_op[i] = OP_RIGHT;
              end
            end
          end else if (key.reached) begin
            out_reached_nxt = 1'b1;
          end else if (count_r == CNT_W'(QUEUE_DEPTH)) begin
            out_ovf_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CNT_W'(1);
            if (any_hit) begin
              if (first_vec[0]) begin
                out_plc_nxt = PLC_FRONT;
              end else if (|(first_vec & gt_vec)) begin
                out_plc_nxt = PLC_GREATER;
              end else begin
                out_plc_nxt = PLC_TIE;
              end
              for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (first_vec[i]) begin
                  cell_op[i] = OP_LOAD;
                end else if (before_vec[i]) begin
                  cell_op[i] = OP_LEFT;
                end
              end
            end else begin
              // Append behind the last entry; an empty store counts as front.
              out_plc_nxt = (count_r == '0) ? PLC_FRONT : PLC_BACK;
              for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (CNT_W'(i) == count_r) begin
                  cell_op[i] = OP_LOAD;
                end
              end
            end
          end
          out_occ_nxt = OCC_W'(count_nxt);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_node      = out_ent_r.node;
  assign out_g         = out_ent_r.g;
  assign out_h         = out_ent_r.h;
  assign out_f         = out_ent_r.f;
  assign out_reached   = out_reached_r;
  assign out_placement = out_plc_r;
  assign out_empty_pop = out_empty_r;
  assign out_overflow  = out_ovf_r;
  assign out_occupancy = out_occ_r;

  // The entry count never passes the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  // At most one cell is chosen as the insertion point.
  a_first_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WRITE |-> $onehot0(first_vec))
    else $error("more than one insertion point");

  // A pop from a non-empty store removes exactly one entry.
  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    commit && action_r == ACT_POP && count_r != '0 |=>
      count_r == $past(count_r) - CNT_W'(1))
    else $error("pop did not remove one entry");

  // A result beat appears only out of the write cycle.
  a_out_from_write: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_WRITE)
    else $error("result raised outside the write cycle");

endmodule
